// File: rtl/nlro_pkg.sv
// ----------------------------------------------------------------------------
// nlro_pkg
// Shared types and constants for the nesting-level to row-offset decoder:
// input and result word layouts, register indexes and sizing defaults.
// ----------------------------------------------------------------------------
package nlro_pkg;

  // default width of the row and element counters
  localparam int unsigned COUNT_BITS_DEF = 32;

  // result queue depth, one item can push two words
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANC_DEF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRUCT   = 2'd3;
  localparam int unsigned CFG_DATA_W = 8;

  // one level pair
  typedef struct packed {
    logic [7:0] def_lvl;
    logic [7:0] rep_lvl;
    logic       batch_last;
  } in_word_t;

  // one row record or end marker
  typedef struct packed {
    logic        row_valid;
    logic [31:0] row_index;
    logic [31:0] row_end_offset;
    logic        row_is_null;
    logic        batch_has_null;
    logic        batch_end;
    logic [31:0] row_total;
  } out_word_t;

endpackage

// File: rtl/nesting_levels_to_row_offsets_top.sv
// ----------------------------------------------------------------------------
// nesting_levels_to_row_offsets_top
// Groups definition/repetition level pairs of a nested column into row
// records: row index, cumulative element offset and null flags per row.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+---------------------
//  in       | input     | in_valid_i/in_stall_o  | nlro_pkg::in_word_t
//  out      | output    | out_valid_o/out_stall_i| nlro_pkg::out_word_t
//  cfg      | input     | cfg_we_i (no wait)     | cfg_idx_i, cfg_data_i
//
//  A level pair is registered on entry and decoded from that register, one pair
//  per cycle while the queue has two free slots, into a four-word result queue.
//  A pair can yield two words (row flush plus batch end); the queue must hold
//  two free slots for a pair to decode.
//  A pair's result words pass through the input register and the result queue.
//  Reset clears the level state and loads the register defaults; no sweep.
//  Stalls on the result side back up through the queue to in_stall_o.
// ----------------------------------------------------------------------------
module nesting_levels_to_row_offsets_top #(
  parameter int unsigned COUNT_BITS = nlro_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nlro_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nlro_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  nlro_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nlro_pkg::out_word_t            out_word_o
);

  localparam int unsigned CW = COUNT_BITS;
  localparam logic [CW-1:0] CNT_MAX = '1;

  // saturating increment
  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CW'(1);
  endfunction

  // clip a counter to the 32-bit result field
  function automatic logic [31:0] clip32(input logic [CW-1:0] v);
    logic [CW+31:0] ext;
    ext = (CW+32)'(v);
    clip32 = ((ext >> 32) != '0) ? 32'hFFFF_FFFF : ext[31:0];
  endfunction

  // configuration registers
  logic [7:0] max_def_q, max_rep_q, anc_def_q;
  logic       struct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_def_q <= 8'd1;
      max_rep_q <= 8'd1;
      anc_def_q <= 8'd0;
      struct_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nlro_pkg::REG_MAX_DEF: max_def_q <= cfg_data_i;
        nlro_pkg::REG_MAX_REP: max_rep_q <= cfg_data_i;
        nlro_pkg::REG_ANC_DEF: anc_def_q <= cfg_data_i;
        nlro_pkg::REG_STRUCT:  struct_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic               stg_valid_q;
  nlro_pkg::in_word_t stg_q;
  logic [nlro_pkg::OUT_CNT_W-1:0] cnt_q;
  logic               advance;

  assign advance    = stg_valid_q && (cnt_q <= nlro_pkg::OUT_CNT_W'(nlro_pkg::OUT_DEPTH - 2));
  assign in_stall_o = stg_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      stg_q <= in_word_i;
    end
  end

  // level state
  logic          pend_q, pnull_q, seen_q;
  logic [CW-1:0] rows_q, elem_q;
  logic          pend_d, pnull_d, seen_d;
  logic [CW-1:0] rows_d, elem_d;

  // decode of the registered pair
  logic      acc, cont, start, is_null, push_a, push_b;
  logic      pend_n, pnull_n, seen_n;
  logic [CW-1:0] rows_n, elem_n;
  nlro_pkg::out_word_t word_a, word_b;

  always_comb begin
    acc   = !((stg_q.def_lvl < anc_def_q) || (stg_q.rep_lvl > max_rep_q));
    cont  = acc && !struct_q && (stg_q.rep_lvl == max_rep_q);
    start = acc && !cont;

    if (struct_q) begin
      is_null = stg_q.def_lvl < max_def_q;
    end else begin
      is_null = ({1'b0, stg_q.def_lvl} + 9'd1) < {1'b0, max_def_q};
    end

    // flush of the previous row when a new one starts
    word_a.row_valid      = 1'b1;
    word_a.row_index      = clip32(rows_q - CW'(1));
    word_a.row_end_offset = clip32(elem_q);
    word_a.row_is_null    = pnull_q;
    word_a.batch_has_null = seen_q;
    word_a.batch_end      = 1'b0;
    word_a.row_total      = 32'd0;
    push_a = advance && start && pend_q;

    rows_n = start ? sat_inc(rows_q) : rows_q;
    elem_n = elem_q;
    if (cont || (start && !struct_q && (stg_q.def_lvl >= max_def_q))) begin
      elem_n = sat_inc(elem_q);
    end
    pend_n  = pend_q | start;
    pnull_n = start ? is_null : pnull_q;
    seen_n  = seen_q | (start && is_null);

    // batch end: last row or empty marker
    word_b.row_valid      = pend_n;
    word_b.row_index      = pend_n ? clip32(rows_n - CW'(1)) : 32'd0;
    word_b.row_end_offset = clip32(elem_n);
    word_b.row_is_null    = pend_n && pnull_n;
    word_b.batch_has_null = seen_n;
    word_b.batch_end      = 1'b1;
    word_b.row_total      = clip32(rows_n);
    push_b = advance && stg_q.batch_last;

    pend_d  = pend_q;
    pnull_d = pnull_q;
    seen_d  = seen_q;
    rows_d  = rows_q;
    elem_d  = elem_q;
    if (advance) begin
      if (stg_q.batch_last) begin
        pend_d  = 1'b0;
        pnull_d = 1'b0;
        seen_d  = 1'b0;
        rows_d  = '0;
        elem_d  = '0;
      end else begin
        pend_d  = pend_n;
        pnull_d = pnull_n;
        seen_d  = seen_n;
        rows_d  = rows_n;
        elem_d  = elem_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      pnull_q <= 1'b0;
      seen_q  <= 1'b0;
      rows_q  <= '0;
      elem_q  <= '0;
    end else begin
      pend_q  <= pend_d;
      pnull_q <= pnull_d;
      seen_q  <= seen_d;
      rows_q  <= rows_d;
      elem_q  <= elem_d;
    end
  end

  // result queue
  nlro_pkg::out_word_t q_mem [nlro_pkg::OUT_DEPTH];
  logic [nlro_pkg::OUT_PTR_W-1:0] wptr_q, rptr_q, wptr_d, rptr_d, wptr_b;
  logic [nlro_pkg::OUT_CNT_W-1:0] cnt_d;
  logic pop;

  assign pop    = out_valid_o && !out_stall_i;
  assign wptr_b = push_a ? wptr_q + nlro_pkg::OUT_PTR_W'(1) : wptr_q;

  always_comb begin
    wptr_d = wptr_q + nlro_pkg::OUT_PTR_W'(push_a) + nlro_pkg::OUT_PTR_W'(push_b);
    rptr_d = rptr_q + nlro_pkg::OUT_PTR_W'(pop);
    cnt_d  = cnt_q + nlro_pkg::OUT_CNT_W'(push_a) + nlro_pkg::OUT_CNT_W'(push_b)
             - nlro_pkg::OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a) begin
      q_mem[wptr_q] <= word_a;
    end
    if (push_b) begin
      q_mem[wptr_b] <= word_b;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = q_mem[rptr_q];

endmodule

// File: rtl/nlro_checker.sv
// ----------------------------------------------------------------------------
// nlro_checker
// Port-level checks on the row-offset decoder's result stream, bound to
// the top level.
// ----------------------------------------------------------------------------
module nlro_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input nlro_pkg::out_word_t out_word_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // a word without a row is only ever the empty end marker
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.row_valid |->
      out_word_o.batch_end && (out_word_o.row_index == 32'd0) && !out_word_o.row_is_null)
    else $error("malformed end marker");

  // row total is only reported on the batch end word
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.batch_end |-> out_word_o.row_total == 32'd0)
    else $error("row total outside batch end");

  // a null row is always reflected in the batch null flag
  a_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.row_is_null |-> out_word_o.batch_has_null)
    else $error("null row without batch null flag");

endmodule

bind nesting_levels_to_row_offsets_top nlro_checker u_nlro_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// File: test/tb_nesting_levels_to_row_offsets_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nesting_levels_to_row_offsets_top
// Self-checking bench for the level-pair to row-record decoder. A directed
// run covers skips, rows that continue before any row exists, end markers,
// zero maximum levels and struct mode. Random batches then run under twelve
// register settings with idle and stall patterns on both channels. Every
// accepted result word is checked against a scoreboard that tracks the row
// state per batch.
// ----------------------------------------------------------------------------
module tb_nesting_levels_to_row_offsets_top;

  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned PHASE_ITEMS   = 88;
  localparam int unsigned SETTLE_CYCLES = 6;

  // row-record scoreboard: tracks the batch state and holds the expected words
  class row_record_scoreboard;
    logic [7:0]  max_def_lvl;
    logic [7:0]  max_rep_lvl;
    logic [7:0]  anc_def_lvl;
    logic        struct_mode;
    logic        pending_row;
    logic        pending_null;
    logic        seen_null;
    logic [31:0] rows_started;
    logic [31:0] element_count;
    nlro_pkg::out_word_t expected_records[$];
    int unsigned error_count;
    int unsigned records_checked;
    int unsigned pairs_noted;

    function new();
      max_def_lvl     = 8'd1;
      max_rep_lvl     = 8'd1;
      anc_def_lvl     = 8'd0;
      struct_mode     = 1'b0;
      error_count     = 0;
      records_checked = 0;
      pairs_noted     = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      pending_row   = 1'b0;
      pending_null  = 1'b0;
      seen_null     = 1'b0;
      rows_started  = 32'd0;
      element_count = 32'd0;
    endfunction

    function void set_reg(logic [nlro_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        nlro_pkg::REG_MAX_DEF: max_def_lvl = data;
        nlro_pkg::REG_MAX_REP: max_rep_lvl = data;
        nlro_pkg::REG_ANC_DEF: anc_def_lvl = data;
        nlro_pkg::REG_STRUCT:  struct_mode = data[0];
        default: ;
      endcase
    endfunction

    // counters hold at all ones
    function logic [31:0] sat_inc(logic [31:0] v);
      return (&v) ? v : v + 32'd1;
    endfunction

    function void push_record(logic valid, logic [31:0] idx, logic isnull, logic last_rec,
                              logic [31:0] total);
      nlro_pkg::out_word_t rec;
      rec.row_valid      = valid;
      rec.row_index      = idx;
      rec.row_end_offset = element_count;
      rec.row_is_null    = isnull;
      rec.batch_has_null = seen_null;
      rec.batch_end      = last_rec;
      rec.row_total      = total;
      expected_records.insert(expected_records.size(), rec);
    endfunction

    // predict the words caused by one accepted level pair
    function void note_level_pair(nlro_pkg::in_word_t w);
      logic takes;
      logic cont;
      logic isnull;
      pairs_noted++;
      takes = !(w.def_lvl < anc_def_lvl || w.rep_lvl > max_rep_lvl);
      if (takes) begin
        cont = !struct_mode && (w.rep_lvl == max_rep_lvl);
        if (cont) begin
          element_count = sat_inc(element_count);
        end else begin
          // a new row flushes the one before it
          if (pending_row)
            push_record(1'b1, rows_started - 32'd1, pending_null, 1'b0, 32'd0);
          rows_started = sat_inc(rows_started);
          if (struct_mode) begin
            isnull = w.def_lvl < max_def_lvl;
          end else begin
            if (w.def_lvl >= max_def_lvl) element_count = sat_inc(element_count);
            // signed def < max - 1
            isnull = ({1'b0, w.def_lvl} + 9'd1) < {1'b0, max_def_lvl};
          end
          pending_row  = 1'b1;
          pending_null = isnull;
          if (isnull) seen_null = 1'b1;
        end
      end
      // batch end: flush or end marker, then start over
      if (w.batch_last) begin
        if (pending_row)
          push_record(1'b1, rows_started - 32'd1, pending_null, 1'b1, rows_started);
        else
          push_record(1'b0, 32'd0, 1'b0, 1'b1, rows_started);
        clear_batch();
      end
    endfunction

    task report(string msg);
      error_count++;
      $display("mismatch: %s", msg);
    endtask

    task check_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
      if (got_v !== exp_v)
        report($sformatf("record %0d %s got 0x%0h expected 0x%0h",
                         records_checked, name, got_v, exp_v));
    endtask

    task check_row_record(nlro_pkg::out_word_t got);
      nlro_pkg::out_word_t exp_rec;
      if (expected_records.size() == 0) begin
        report($sformatf("unexpected record after %0d checked", records_checked));
        return;
      end
      exp_rec = expected_records.pop_front();
      check_field("row_valid", 32'(got.row_valid), 32'(exp_rec.row_valid));
      check_field("row_index", got.row_index, exp_rec.row_index);
      check_field("row_end_offset", got.row_end_offset, exp_rec.row_end_offset);
      check_field("row_is_null", 32'(got.row_is_null), 32'(exp_rec.row_is_null));
      check_field("batch_has_null", 32'(got.batch_has_null), 32'(exp_rec.batch_has_null));
      check_field("batch_end", 32'(got.batch_end), 32'(exp_rec.batch_end));
      check_field("row_total", got.row_total, exp_rec.row_total);
      records_checked++;
    endtask
  endclass

  logic                            clk_i      = 1'b0;
  logic                            rst_ni     = 1'b0;
  logic                            cfg_we_i   = 1'b0;
  logic [nlro_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = nlro_pkg::REG_MAX_DEF;
  logic [nlro_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  nlro_pkg::in_word_t              in_word_i  = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  nlro_pkg::out_word_t             out_word_o;

  row_record_scoreboard  sb;
  int unsigned           send_idle_pct = 0;
  int unsigned           stall_pct     = 0;
  int unsigned           quiet_cycles  = 0;

  nesting_levels_to_row_offsets_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // monitor at mid-cycle: handshakes seen here complete at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_level_pair(in_word_i);
      if (out_valid_o && !out_stall_i) sb.check_row_record(out_word_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
          $display("[nesting_levels_to_row_offsets_top] ERROR");
          $finish;
        end
      end
    end
  end

  function automatic nlro_pkg::in_word_t level_pair(logic [7:0] d, logic [7:0] r, logic l);
    nlro_pkg::in_word_t w;
    w.def_lvl    = d;
    w.rep_lvl    = r;
    w.batch_last = l;
    return w;
  endfunction

  // mostly well-formed levels for the current setting, some raw noise
  function automatic nlro_pkg::in_word_t random_pair();
    nlro_pkg::in_word_t w;
    int       lo;
    int       hi;
    lo = sb.anc_def_lvl;
    hi = sb.max_def_lvl + 1;
    if (hi > 255) hi = 255;
    if (hi < lo) hi = lo;
    if ($urandom_range(0, 99) < 82) begin
      w.def_lvl = 8'($urandom_range(hi, lo));
      w.rep_lvl = $urandom_range(0, 1) ? sb.max_rep_lvl
                                       : 8'($urandom_range(sb.max_rep_lvl, 0));
    end else begin
      w.def_lvl = 8'($urandom_range(0, 255));
      w.rep_lvl = 8'($urandom_range(0, 255));
    end
    w.batch_last = ($urandom_range(0, 9) == 0);
    return w;
  endfunction

  // present one word and hold it until taken
  task send_pair(input nlro_pkg::in_word_t w);
    logic taken;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
  endtask

  // hold off input until every expected word is out, then let the pipe settle
  task quiesce();
    in_valid_i <= 1'b0;
    while (sb.expected_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task write_reg(input logic [nlro_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task write_config(input logic [7:0] md, input logic [7:0] mr, input logic [7:0] ad,
                    input logic sm);
    write_reg(nlro_pkg::REG_MAX_DEF, md);
    write_reg(nlro_pkg::REG_MAX_REP, mr);
    write_reg(nlro_pkg::REG_ANC_DEF, ad);
    write_reg(nlro_pkg::REG_STRUCT, {7'd0, sm});
    cfg_we_i <= 1'b0;
  endtask

  // one random phase under one register setting and one idle pattern
  task run_phase(input logic [7:0] md, input logic [7:0] mr, input logic [7:0] ad,
                 input logic sm, input int unsigned mode, input bit pause_mid);
    nlro_pkg::in_word_t w;
    quiesce();
    write_config(md, mr, ad, sm);
    send_idle_pct = (mode == 1) ? 76 : (mode == 3) ? 31 : 0;
    stall_pct     = (mode == 2) ? 76 : (mode == 3) ? 31 : 0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (pause_mid && i == PHASE_ITEMS / 2) quiesce();
      w = random_pair();
      // close the batch before the next setting
      if (i == PHASE_ITEMS - 1) w.batch_last = 1'b1;
      send_pair(w);
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: list mode with an ancestor level
    write_config(8'd3, 8'd2, 8'd1, 1'b0);
    send_pair(level_pair(8'd3, 8'd2, 1'b0));     // element before any row
    send_pair(level_pair(8'd0, 8'd0, 1'b0));     // below ancestor, skipped
    send_pair(level_pair(8'd3, 8'd3, 1'b0));     // repetition too deep, skipped
    send_pair(level_pair(8'd3, 8'd0, 1'b0));     // new row with an element
    send_pair(level_pair(8'd2, 8'd2, 1'b0));     // continue
    send_pair(level_pair(8'd1, 8'd1, 1'b0));     // null row
    send_pair(level_pair(8'd2, 8'd0, 1'b0));     // empty row
    send_pair(level_pair(8'd255, 8'd255, 1'b0)); // skipped at the top
    send_pair(level_pair(8'd255, 8'd2, 1'b1));   // continue then flush
    send_pair(level_pair(8'd0, 8'd0, 1'b1));     // end marker, nothing pending
    send_pair(level_pair(8'd255, 8'd0, 1'b1));   // single row batch
    // zero max definition level: no nulls
    quiesce();
    write_config(8'd0, 8'd1, 8'd0, 1'b0);
    send_pair(level_pair(8'd0, 8'd0, 1'b0));
    send_pair(level_pair(8'd0, 8'd1, 1'b0));
    send_pair(level_pair(8'd0, 8'd0, 1'b1));
    // zero max repetition level: rows never start
    quiesce();
    write_config(8'd2, 8'd0, 8'd0, 1'b0);
    send_pair(level_pair(8'd0, 8'd0, 1'b0));
    send_pair(level_pair(8'd5, 8'd0, 1'b0));
    send_pair(level_pair(8'd0, 8'd1, 1'b1));
    // struct mode: every accepted pair is a row, offsets stay zero
    quiesce();
    write_config(8'd2, 8'd1, 8'd0, 1'b1);
    send_pair(level_pair(8'd2, 8'd1, 1'b0));
    send_pair(level_pair(8'd1, 8'd0, 1'b0));
    send_pair(level_pair(8'd0, 8'd255, 1'b0));
    send_pair(level_pair(8'd255, 8'd0, 1'b1));

    // random batches
    run_phase(8'd1,   8'd1,   8'd0,   1'b0, 0, 1'b0);
    run_phase(8'd3,   8'd2,   8'd1,   1'b0, 1, 1'b1);
    run_phase(8'd0,   8'd0,   8'd0,   1'b0, 2, 1'b0);
    run_phase(8'd255, 8'd255, 8'd0,   1'b0, 3, 1'b0);
    run_phase(8'd255, 8'd255, 8'd255, 1'b0, 0, 1'b0);
    run_phase(8'd4,   8'd3,   8'd2,   1'b1, 1, 1'b0);
    run_phase(8'd0,   8'd0,   8'd0,   1'b1, 2, 1'b1);
    run_phase(8'd255, 8'd255, 8'd255, 1'b1, 3, 1'b0);
    run_phase(8'd2,   8'd1,   8'd0,   1'b0, 0, 1'b0);
    run_phase(8'd6,   8'd4,   8'd0,   1'b0, 1, 1'b0);
    run_phase(8'd1,   8'd0,   8'd0,   1'b1, 2, 1'b0);
    run_phase(8'd8,   8'd8,   8'd3,   1'b0, 3, 1'b0);

    // drain and check for leftovers
    quiesce();
    if (sb.expected_records.size() != 0)
      sb.report($sformatf("%0d expected records never arrived", sb.expected_records.size()));

    $display("run covered %0d level pairs and %0d row words over 12 random settings",
             sb.pairs_noted, sb.records_checked);
    $display("directed: skips, early elements, end markers, zero levels, struct mode");
    if (sb.error_count == 0) begin
      $display("[nesting_levels_to_row_offsets_top] OK");
    end else begin
      $display("[nesting_levels_to_row_offsets_top] ERROR");
    end
    $finish;
  end

endmodule
